// ----- sv/frba_pkg.sv -----
package frba_pkg;

  localparam int FENCE_DEPTH = 16;
  localparam int OFFSET_BITS = 32;
  localparam int IDX_W       = $clog2(FENCE_DEPTH);
  localparam int CNT_W       = $clog2(FENCE_DEPTH + 1);

  typedef logic [OFFSET_BITS-1:0] ofs_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  localparam logic       CMD_RESERVE  = 1'b0;
  localparam logic       CMD_COMMIT   = 1'b1;
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_SUBMIT    = 2'd2;
  localparam logic [1:0] ST_OVER      = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [31:0] byte_count;
    logic [16:0] alignment;
    logic [63:0] completed_fence;
    logic [63:0] current_fence;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] write_offset;
    logic [31:0] free_space;
    logic        wait_needed;
    logic [63:0] wait_fence;
    logic        fence_overflow;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LATCH, OP_CHECK, OP_RET_RD, OP_RET_EV, OP_RET_END, OP_REM, OP_FAST,
    OP_SRCH_RD, OP_SRCH_EV, OP_SUBMIT, OP_SELECT, OP_FINISH, OP_CMT_RD, OP_COMMIT, OP_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctl_t;

  typedef struct packed {
    logic is_commit;
    logic too_large;
    logic more;
    logic hit;
    logic found;
    logic rem_busy;
    logic fast_ok;
    logic cur_match;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/frba_ram.sv -----
module frba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/frba_rem.sv -----
module frba_rem import frba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  ofs_t        x_i,
  input  logic [16:0] a_i,
  output logic        busy_o,
  output logic [16:0] rem_o
);

  localparam int STEP_W = $clog2(OFFSET_BITS + 1);

  logic [16:0]       a_eff;
  logic              pow2;
  logic [16:0]       a_q;
  ofs_t              x_q;
  logic [16:0]       r_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q;
  logic [17:0]       t;

  assign a_eff = (a_i == 17'd0) ? 17'd1 : a_i;
  assign pow2  = (a_eff & (a_eff - 17'd1)) == 17'd0;
  assign t     = {r_q, x_q[OFFSET_BITS-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= !pow2;
      cnt_q  <= STEP_W'(OFFSET_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_eff;
      x_q <= x_i;
      r_q <= pow2 ? (17'(x_i) & (a_eff - 17'd1)) : 17'd0;
    end else if (busy_q) begin
      x_q <= x_q << 1;
      r_q <= (t >= 18'(a_q)) ? 17'(t - 18'(a_q)) : 17'(t);
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = r_q;

endmodule

// ----- sv/frba_dp.sv -----
module frba_dp import frba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  output sts_t        sts_o,
  input  req_t        in_req_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_rsp_o
);

  function automatic idx_t slot(idx_t h, cnt_t n);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(n);
    if (s >= (CNT_W+1)'(FENCE_DEPTH)) s = s - (CNT_W+1)'(FENCE_DEPTH);
    return idx_t'(s);
  endfunction

  function automatic ofs_t sub0(ofs_t a, ofs_t b);
    return (a > b) ? a - b : '0;
  endfunction

  logic [31:0] bsize_q;
  ofs_t        wp_q, sp_q, cp_q;
  idx_t        head_q;
  cnt_t        count_q;
  req_t        req_q;
  cnt_t        idx_q;
  logic [63:0] fctr_q, wfence_q;
  ofs_t        foff_q, nwp_q, nsp_q, ngp_q;
  logic [1:0]  st_q;
  logic        ovf_q;
  rsp_t        out_q;
  logic        out_valid_q;

  dp_op_e      op;
  ofs_t        size, size_m_wp, wpa;
  logic [32:0] req_sum;
  logic [16:0] a_eff, rem, adj;
  logic        rem_busy;
  idx_t        rd_idx, wr_idx;
  logic [63:0] ctr_rd;
  ofs_t        off_rd;
  logic        fast_ok, found, last_match, over;
  ofs_t        fast_wp, fast_sp, s_nwp, s_nsp, s_ngp, cmt_wp;
  logic        we_ctr, we_off;
  cnt_t        drop_n;
  logic [32:0] sp_fin;

  assign op        = ctl_i.op;
  assign size      = ofs_t'(bsize_q);
  assign req_sum   = {1'b0, req_q.byte_count} + 33'(req_q.alignment);
  assign a_eff     = (req_q.alignment == 17'd0) ? 17'd1 : req_q.alignment;
  assign adj       = (rem == 17'd0) ? 17'd0 : a_eff - rem;
  assign wpa       = wp_q + ofs_t'(adj);
  assign size_m_wp = sub0(size, wp_q);
  assign rd_idx    = slot(head_q, (op == OP_CMT_RD) ? count_q - cnt_t'(1) : idx_q);

  frba_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(op == OP_REM || op == OP_SELECT),
    .x_i    ((op == OP_SELECT) ? nwp_q : wp_q),
    .a_i    (req_q.alignment),
    .busy_o (rem_busy),
    .rem_o  (rem)
  );

  frba_ram #(.WIDTH(64), .DEPTH(FENCE_DEPTH)) u_ctr_ram (
    .clk_i  (clk_i),
    .we_i   (we_ctr),
    .waddr_i(wr_idx),
    .wdata_i(req_q.current_fence),
    .raddr_i(rd_idx),
    .rdata_o(ctr_rd)
  );

  frba_ram #(.WIDTH(OFFSET_BITS), .DEPTH(FENCE_DEPTH)) u_off_ram (
    .clk_i  (clk_i),
    .we_i   (we_off),
    .waddr_i(wr_idx),
    .wdata_i(cmt_wp),
    .raddr_i(rd_idx),
    .rdata_o(off_rd)
  );

  always_comb begin
    fast_ok = 1'b0;
    fast_wp = wpa;
    fast_sp = sub0(size, wpa);
    if (wp_q >= cp_q) begin
      if (req_sum <= 33'(size_m_wp)) begin
        fast_ok = 1'b1;
      end else if (req_sum < 33'(cp_q)) begin
        fast_ok = 1'b1;
        fast_wp = '0;
        fast_sp = cp_q - ofs_t'(1);
      end
    end else if (req_sum < 33'(cp_q - wp_q)) begin
      fast_ok = 1'b1;
      fast_sp = sub0(sub0(cp_q, wpa), ofs_t'(1));
    end
  end

  always_comb begin
    found = 1'b0;
    s_nwp = wp_q;
    s_nsp = size_m_wp;
    s_ngp = off_rd;
    if (wp_q == off_rd) begin
      found = 1'b1;
      s_nwp = '0;
      s_nsp = size;
      s_ngp = '0;
    end else if (wp_q > off_rd) begin
      if (33'(size_m_wp) >= req_sum) begin
        found = 1'b1;
      end else if (33'(off_rd) > req_sum) begin
        found = 1'b1;
        s_nwp = '0;
        s_nsp = off_rd - ofs_t'(1);
      end
    end else if (33'(off_rd - wp_q) > req_sum) begin
      found = 1'b1;
      s_nsp = off_rd - wp_q - ofs_t'(1);
    end
  end

  assign cmt_wp     = wp_q + ofs_t'(req_q.byte_count);
  assign over       = ({1'b0, req_q.byte_count} > 33'(sp_q)) ||
                      (33'(wp_q) + 33'(req_q.byte_count) > 33'(size));
  assign last_match = (count_q != '0) && (ctr_rd == req_q.current_fence);
  assign wr_idx     = slot(head_q, last_match ? count_q - cnt_t'(1) : count_q);
  assign we_ctr     = (op == OP_COMMIT) && !over && !last_match &&
                      (count_q < cnt_t'(FENCE_DEPTH));
  assign we_off     = (op == OP_COMMIT) && !over && (last_match || we_ctr);
  assign drop_n     = (wp_q == foff_q) ? count_q : idx_q + cnt_t'(1);
  assign sp_fin     = (33'(sp_q) > 33'(adj)) ? 33'(sp_q) - 33'(adj) : 33'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q     <= '0;
      wp_q        <= '0;
      sp_q        <= '0;
      cp_q        <= '0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op == OP_LOAD) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        bsize_q <= cfg_data_i;
        wp_q    <= '0;
        cp_q    <= '0;
        head_q  <= '0;
        count_q <= '0;
      end
      case (op)
        OP_RET_EV: begin
          if (req_q.completed_fence >= ctr_rd) cp_q <= off_rd;
        end
        OP_RET_END: begin
          if (idx_q != '0) begin
            head_q  <= slot(head_q, idx_q);
            count_q <= count_q - idx_q;
            if (wp_q == cp_q) begin
              wp_q <= '0;
              cp_q <= '0;
              sp_q <= size;
            end
          end
        end
        OP_FAST: begin
          if (fast_ok) begin
            wp_q <= fast_wp;
            sp_q <= fast_sp;
          end
        end
        OP_SELECT: begin
          if (fctr_q != req_q.current_fence) begin
            head_q  <= slot(head_q, drop_n);
            count_q <= count_q - drop_n;
            wp_q    <= nwp_q;
            sp_q    <= nsp_q;
            cp_q    <= ngp_q;
          end
        end
        OP_FINISH: begin
          wp_q <= wpa;
          sp_q <= ofs_t'(sp_fin);
        end
        OP_COMMIT: begin
          if (!over) begin
            wp_q <= cmt_wp;
            sp_q <= sp_q - ofs_t'(req_q.byte_count);
            if (we_ctr) count_q <= count_q + cnt_t'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      OP_LATCH: begin
        req_q    <= in_req_i;
        wfence_q <= '0;
        ovf_q    <= 1'b0;
        st_q     <= ST_OK;
        idx_q    <= '0;
      end
      OP_CHECK: begin
        if (req_q.cmd == CMD_RESERVE && req_sum > 33'(size)) st_q <= ST_TOO_LARGE;
      end
      OP_RET_EV: begin
        if (req_q.completed_fence >= ctr_rd) idx_q <= idx_q + cnt_t'(1);
      end
      OP_RET_END: idx_q <= '0;
      OP_SRCH_EV: begin
        if (found) begin
          nwp_q  <= s_nwp;
          nsp_q  <= s_nsp;
          ngp_q  <= s_ngp;
          fctr_q <= ctr_rd;
          foff_q <= off_rd;
        end else begin
          idx_q <= idx_q + cnt_t'(1);
        end
      end
      OP_SUBMIT: st_q <= ST_SUBMIT;
      OP_SELECT: begin
        if (fctr_q == req_q.current_fence) st_q <= ST_SUBMIT;
        else wfence_q <= fctr_q;
      end
      OP_COMMIT: begin
        if (over) st_q <= ST_OVER;
        else ovf_q <= !last_match && (count_q >= cnt_t'(FENCE_DEPTH));
      end
      OP_LOAD: begin
        out_q.status         <= st_q;
        out_q.write_offset   <= 32'(wp_q);
        out_q.free_space     <= 32'(sp_q);
        out_q.wait_needed    <= wfence_q != '0;
        out_q.wait_fence     <= wfence_q;
        out_q.fence_overflow <= ovf_q;
      end
      default: ;
    endcase
  end

  assign sts_o.is_commit = req_q.cmd == CMD_COMMIT;
  assign sts_o.too_large = req_sum > 33'(size);
  assign sts_o.more      = idx_q < count_q;
  assign sts_o.hit       = req_q.completed_fence >= ctr_rd;
  assign sts_o.found     = found;
  assign sts_o.rem_busy  = rem_busy;
  assign sts_o.fast_ok   = fast_ok;
  assign sts_o.cur_match = fctr_q == req_q.current_fence;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ----- sv/frba_ctrl.sv -----
module frba_ctrl import frba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic cfg_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RET_RD, S_RET_EV, S_RET_END, S_REM, S_REM_WAIT, S_FAST,
    S_SRCH_RD, S_SRCH_EV, S_SUBMIT, S_SELECT, S_FIN_WAIT, S_FINISH, S_CMT_RD,
    S_COMMIT, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;
  dp_op_e op;

  always_comb begin
    state_d = state_q;
    op      = OP_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LATCH;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        op = OP_CHECK;
        if (sts_i.is_commit) state_d = S_CMT_RD;
        else if (sts_i.too_large) state_d = S_DONE;
        else state_d = S_RET_RD;
      end
      S_RET_RD: begin
        op      = OP_RET_RD;
        state_d = sts_i.more ? S_RET_EV : S_RET_END;
      end
      S_RET_EV: begin
        op      = OP_RET_EV;
        state_d = sts_i.hit ? S_RET_RD : S_RET_END;
      end
      S_RET_END: begin
        op      = OP_RET_END;
        state_d = S_REM;
      end
      S_REM: begin
        op      = OP_REM;
        state_d = S_REM_WAIT;
      end
      S_REM_WAIT: begin
        if (!sts_i.rem_busy) state_d = S_FAST;
      end
      S_FAST: begin
        op      = OP_FAST;
        state_d = sts_i.fast_ok ? S_DONE : S_SRCH_RD;
      end
      S_SRCH_RD: begin
        op      = OP_SRCH_RD;
        state_d = sts_i.more ? S_SRCH_EV : S_SUBMIT;
      end
      S_SRCH_EV: begin
        op      = OP_SRCH_EV;
        state_d = sts_i.found ? S_SELECT : S_SRCH_RD;
      end
      S_SUBMIT: begin
        op      = OP_SUBMIT;
        state_d = S_DONE;
      end
      S_SELECT: begin
        op      = OP_SELECT;
        state_d = sts_i.cur_match ? S_DONE : S_FIN_WAIT;
      end
      S_FIN_WAIT: begin
        if (!sts_i.rem_busy) state_d = S_FINISH;
      end
      S_FINISH: begin
        op      = OP_FINISH;
        state_d = S_DONE;
      end
      S_CMT_RD: begin
        op      = OP_CMT_RD;
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        op      = OP_COMMIT;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          op      = OP_LOAD;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= state_d != S_IDLE;
    end
  end

  assign in_stall_o  = stall_q;
  assign cfg_ready_o = !stall_q;
  assign ctl_o.op    = op;

endmodule

// ----- sv/fenced_ring_buffer_allocator.sv -----
// channel  direction  handshake              payload
// in       input      in_valid_i / in_stall_o   in_req_i (req_t)
// out      output     out_valid_o / out_stall_i out_rsp_o (rsp_t)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (buffer size)
//
// Commit: the newest fence entry is read from its RAM, then the commit is applied.
// Reserve: completed fence entries are retired, the alignment remainder is taken, a
// fast fit is tried and, if it fails, the queue is searched for a gap; on a wait the
// entry is selected and the offset aligned anew. A remainder (one, or two on a wait)
// is bit-serial unless the alignment is a power of two; queue entries are read singly.
// Reset clears offsets, space and the fence queue at once; no clearing pass.
// A finished result waits in the output register while the next request is taken.
module fenced_ring_buffer_allocator import frba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  ctl_t ctl;
  sts_t sts;

  frba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_ready_o(cfg_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  frba_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .in_req_i   (in_req_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted without going busy");

  a_wait_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.wait_needed |-> out_rsp_o.status == ST_OK)
    else $error("wait fence on a failed request");

  a_overflow_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.fence_overflow |-> out_rsp_o.status == ST_OK)
    else $error("fence overflow on a failed request");

  a_wait_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.wait_needed == (out_rsp_o.wait_fence != '0))
    else $error("wait flag disagrees with wait fence");

endmodule

// ----- tb/frba_checker.sv -----
module frba_checker import frba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  req_t        in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  rsp_t        out_rsp_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  output int          mismatches_o,
  output int          pending_o
);

  localparam logic [63:0] OFS_MASK = (64'd1 << OFFSET_BITS) - 64'd1;

  logic [63:0] ring_size;
  logic [63:0] wr_pos;
  logic [63:0] space;
  logic [63:0] cons_pos;
  logic [63:0] fence_ctr [FENCE_DEPTH];
  logic [63:0] fence_ofs [FENCE_DEPTH];
  int          fence_head;
  int          fence_cnt;
  rsp_t        expected_rsp [$];

  function automatic int slot(int i);
    return (fence_head + i) % FENCE_DEPTH;
  endfunction

  function automatic logic [63:0] sub0(logic [63:0] a, logic [63:0] b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  function automatic logic [63:0] align_up(logic [63:0] x, logic [63:0] a);
    return (x + a - 64'd1) / a * a;
  endfunction

  task automatic drop_front(int n);
    if (n > fence_cnt) n = fence_cnt;
    fence_head = (fence_head + n) % FENCE_DEPTH;
    fence_cnt  = fence_cnt - n;
  endtask

  task automatic clear_ring();
    wr_pos     = 0;
    cons_pos   = 0;
    fence_head = 0;
    fence_cnt  = 0;
    for (int k = 0; k < FENCE_DEPTH; k++) begin
      fence_ctr[k] = 0;
      fence_ofs[k] = 0;
    end
  endtask

  task automatic predict_reserve(input logic [63:0] bytes, input logic [63:0] align,
                                 input logic [63:0] done, input logic [63:0] cur,
                                 output logic [1:0] st, output logic [63:0] wf);
    logic [63:0] size, req, a, nwp, nsp, ngp, gp, diff;
    int          n;
    int          sel;
    bit          found;
    size  = ring_size & OFS_MASK;
    req   = bytes + align;
    a     = (align == 0) ? 64'd1 : align;
    wf    = 0;
    st    = ST_OK;
    found = 0;
    sel   = 0;
    n     = 0;
    nwp   = 0;
    nsp   = 0;
    ngp   = 0;
    if (req > size) begin
      st = ST_TOO_LARGE;
      return;
    end
    while (n < fence_cnt && done >= fence_ctr[slot(n)]) begin
      cons_pos = fence_ofs[slot(n)];
      n++;
    end
    if (n > 0) begin
      drop_front(n);
      if (wr_pos == cons_pos) begin
        wr_pos   = 0;
        cons_pos = 0;
        space    = size;
      end
    end
    if (wr_pos >= cons_pos) begin
      if (req <= sub0(size, wr_pos)) begin
        wr_pos = align_up(wr_pos, a) & OFS_MASK;
        space  = sub0(size, wr_pos);
        return;
      end
      if (req < cons_pos) begin
        wr_pos = 0;
        space  = cons_pos - 64'd1;
        return;
      end
    end else if (req < cons_pos - wr_pos) begin
      wr_pos = align_up(wr_pos, a) & OFS_MASK;
      space  = sub0(sub0(cons_pos, wr_pos), 64'd1);
      return;
    end
    for (int i = 0; i < fence_cnt && !found; i++) begin
      gp = fence_ofs[slot(i)];
      if (wr_pos == gp) begin
        nwp = 0; nsp = size; ngp = 0; found = 1;
      end else if (wr_pos > gp) begin
        if (sub0(size, wr_pos) >= req) begin
          nwp = wr_pos; nsp = sub0(size, wr_pos); ngp = gp; found = 1;
        end else if (gp > req) begin
          nwp = 0; nsp = gp - 64'd1; ngp = gp; found = 1;
        end
      end else if (gp - wr_pos > req) begin
        nwp = wr_pos; nsp = gp - wr_pos - 64'd1; ngp = gp; found = 1;
      end
      if (found) sel = i;
    end
    if (!found || fence_ctr[slot(sel)] == cur) begin
      st = ST_SUBMIT;
      return;
    end
    wf = fence_ctr[slot(sel)];
    drop_front((wr_pos == fence_ofs[slot(sel)]) ? fence_cnt : sel + 1);
    wr_pos   = nwp;
    space    = nsp;
    cons_pos = ngp;
    diff     = align_up(wr_pos, a) - wr_pos;
    wr_pos   = (wr_pos + diff) & OFS_MASK;
    space    = sub0(space, diff);
  endtask

  task automatic predict_request(input req_t r);
    rsp_t        e;
    logic [1:0]  st;
    logic [63:0] wf;
    logic [63:0] bytes;
    logic [63:0] size;
    bit          ovf;
    st    = ST_OK;
    wf    = 0;
    ovf   = 0;
    bytes = {32'd0, r.byte_count};
    size  = ring_size & OFS_MASK;
    if (r.cmd == CMD_RESERVE) begin
      predict_reserve(bytes, {47'd0, r.alignment}, r.completed_fence, r.current_fence, st, wf);
    end else if (bytes > space || wr_pos + bytes > size) begin
      st = ST_OVER;
    end else begin
      wr_pos = (wr_pos + bytes) & OFS_MASK;
      space  = space - bytes;
      if (fence_cnt > 0 && fence_ctr[slot(fence_cnt - 1)] == r.current_fence) begin
        fence_ofs[slot(fence_cnt - 1)] = wr_pos;
      end else if (fence_cnt < FENCE_DEPTH) begin
        fence_ctr[slot(fence_cnt)] = r.current_fence;
        fence_ofs[slot(fence_cnt)] = wr_pos;
        fence_cnt++;
      end else begin
        ovf = 1;
      end
    end
    e.status         = st;
    e.write_offset   = wr_pos[31:0];
    e.free_space     = space[31:0];
    e.wait_needed    = (wf != 0);
    e.wait_fence     = wf;
    e.fence_overflow = ovf;
    expected_rsp.push_back(e);
  endtask

  task automatic compare_rsp(input rsp_t a);
    rsp_t e;
    if (expected_rsp.size() == 0) begin
      $error("unexpected response %h", a);
      mismatches_o++;
      return;
    end
    e = expected_rsp.pop_front();
    if (a.status !== e.status) begin
      $error("status: expected %0d actual %0d", e.status, a.status);
      mismatches_o++;
    end
    if (a.write_offset !== e.write_offset) begin
      $error("write_offset: expected %0d actual %0d", e.write_offset, a.write_offset);
      mismatches_o++;
    end
    if (a.free_space !== e.free_space) begin
      $error("free_space: expected %0d actual %0d", e.free_space, a.free_space);
      mismatches_o++;
    end
    if (a.wait_needed !== e.wait_needed) begin
      $error("wait_needed: expected %0d actual %0d", e.wait_needed, a.wait_needed);
      mismatches_o++;
    end
    if (a.wait_fence !== e.wait_fence) begin
      $error("wait_fence: expected %0d actual %0d", e.wait_fence, a.wait_fence);
      mismatches_o++;
    end
    if (a.fence_overflow !== e.fence_overflow) begin
      $error("fence_overflow: expected %0d actual %0d", e.fence_overflow, a.fence_overflow);
      mismatches_o++;
    end
  endtask

  initial mismatches_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size = 0;
      space     = 0;
      clear_ring();
      expected_rsp.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) compare_rsp(out_rsp_i);
      if (cfg_valid_i && cfg_ready_i) begin
        ring_size = {32'd0, cfg_data_i};
        clear_ring();
      end
      if (in_valid_i && !in_stall_i) predict_request(in_req_i);
      pending_o = expected_rsp.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import frba_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  req_t        in_req;
  logic        out_valid;
  logic        out_stall;
  rsp_t        out_rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  int          mismatches;
  int          pending;
  int          idle_max;
  int          out_hold;
  int          quiet_cycles;
  logic [63:0] cur_fence;
  logic [63:0] done_fence;
  logic [31:0] last_reserve;

  fenced_ring_buffer_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  frba_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_rsp_i    (out_rsp),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else if (out_valid && !out_stall) begin
      out_hold  <= $urandom_range(0, idle_max);
      out_stall <= 1'b0;
      if (idle_max > 0 && $urandom_range(0, 1)) begin
        out_stall <= 1'b1;
      end
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      if (out_hold == 1) out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL fenced_ring_buffer_allocator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input req_t r);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t mk(logic c, logic [31:0] b, logic [16:0] a,
                              logic [63:0] d, logic [63:0] f);
    req_t r;
    r.cmd             = c;
    r.byte_count      = b;
    r.alignment       = a;
    r.completed_fence = d;
    r.current_fence   = f;
    return r;
  endfunction

  function automatic req_t random_request(logic [31:0] size);
    req_t        r;
    int          pick;
    logic [31:0] span;
    span = (size / 4 > 32'h4000_0000) ? 32'h4000_0000 : size / 4;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      last_reserve = $urandom_range(0, span);
      r = mk(CMD_RESERVE, last_reserve, 17'd1 << $urandom_range(0, 6), done_fence, cur_fence);
    end else if (pick < 88) begin
      r = mk(CMD_COMMIT, $urandom_range(0, last_reserve), 17'd1, done_fence, cur_fence);
      if ($urandom_range(0, 9) < 3) cur_fence = cur_fence + 1;
      if ($urandom_range(0, 3) == 0) begin
        done_fence = cur_fence - $urandom_range(0, 3);
      end
    end else begin
      r = mk(1'($urandom_range(0, 1)), $urandom, 17'($urandom_range(1, 65536)),
             {$urandom, $urandom}, {$urandom, $urandom});
      if (pick < 94) r.byte_count = $urandom_range(0, span);
    end
    return r;
  endfunction

  task automatic run_phase(input logic [31:0] size, input int count);
    write_size(size);
    cur_fence    = 64'd5;
    done_fence   = 64'd3;
    last_reserve = 0;
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 0) idle_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      if (k == count / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      send_request(random_request(size));
    end
    drain();
  endtask

  initial begin
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    idle_max  = 4;
    quiet_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // before any size is set
    send_request(mk(CMD_RESERVE, 32'd0, 17'd1, 64'd0, 64'd0));
    send_request(mk(CMD_COMMIT, 32'd0, 17'd1, 64'd0, 64'd1));
    drain();

    write_size(32'd256);
    send_request(mk(CMD_RESERVE, 32'd0, 17'd1, 64'd0, 64'd1));
    send_request(mk(CMD_RESERVE, 32'd0, 17'd65536, 64'd0, 64'd1));
    send_request(mk(CMD_RESERVE, 32'hFFFF_FFFF, 17'd1, 64'd0, 64'd1));
    send_request(mk(CMD_RESERVE, 32'd10, 17'd0, 64'd0, 64'd1));
    send_request(mk(CMD_COMMIT, 32'd5, 17'd1, 64'd0, 64'd1));
    send_request(mk(CMD_RESERVE, 32'd8, 17'd3, 64'd0, 64'd1));
    send_request(mk(CMD_COMMIT, 32'd300, 17'd1, 64'd0, 64'd1));
    for (int k = 2; k < 19; k++) begin
      send_request(mk(CMD_COMMIT, 32'd4, 17'd1, 64'd0, 64'(k)));
    end
    send_request(mk(CMD_RESERVE, 32'd200, 17'd4, 64'd0, 64'd2));
    send_request(mk(CMD_RESERVE, 32'd200, 17'd4, 64'd3, 64'd18));
    send_request(mk(CMD_RESERVE, 32'd40, 17'd1, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'hFFFF_FFFF_FFFF_FFFF));
    drain();

    run_phase(32'd256, 240);
    run_phase(32'hFFFF_FFFF, 200);
    run_phase(32'd1000, 240);
    run_phase(32'd64, 200);
    run_phase(32'd0, 60);
    run_phase(32'd4096, 240);
    run_phase(32'd100000, 200);

    if (mismatches == 0 && pending == 0) begin
      $display("PASS fenced_ring_buffer_allocator");
    end else begin
      $display("FAIL fenced_ring_buffer_allocator");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/frba_pkg.sv
sv/frba_ram.sv
sv/frba_rem.sv
sv/frba_dp.sv
sv/frba_ctrl.sv
sv/fenced_ring_buffer_allocator.sv
tb/frba_checker.sv
tb/testbench.sv
